// ----- hw/rtl/simplex_noise_2d_fbm_core_assert.svh -----
// Assertion macros used by the top level of the simplex noise core.
`ifndef SIMPLEX_NOISE_2D_FBM_CORE_ASSERT_SVH
`define SIMPLEX_NOISE_2D_FBM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SN2F_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SN2F_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SN2F_ASSERT(lbl, prop, msg)
`define SN2F_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/sn2f_pkg.sv -----
// Types, constants and tables of the simplex noise core.
package sn2f_pkg;
	localparam int MAX_OCTAVES = 8;
	localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
	localparam int SCALE_W = 24;
	localparam int COUNT_W = 4;
	localparam int PERS_W = 16;
	localparam int COORD_W = 32;
	localparam int NOISE_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam int XP_W = COORD_W + SCALE_W;
	localparam int PT_W = 40;
	localparam int LAT_W = 24;
	localparam int FRAC_W = 16;
	localparam int F2Q = 23988;
	localparam int G2Q = 13849;
	localparam int NOISE_GAIN = 70;
	localparam int CRN_W = 19;
	localparam int SQ_W = 2 * CRN_W;
	localparam int DOT_W = CRN_W + 1;
	localparam int TV_W = 32;
	localparam int T2_W = 31;
	localparam int T4_W = 29;
	localparam int TERM_W = T4_W + 1 + DOT_W;
	localparam int SUM3_W = TERM_W + 2;
	localparam int N_W = 34;
	localparam int AMP_W = 15 + MAX_OCTAVES;
	localparam int NORM_W = 16 + MAX_OCTAVES;
	localparam int PROD_W = N_W + AMP_W + 1;
	localparam int TOT_W = N_W + AMP_W - 15 + CNT_W + 1;
	localparam int Q_W = 17;
	localparam int SH_W = 5;
	localparam int AMP_ONE = 32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE = 2'd0,
		REG_OCTAVES = 2'd1,
		REG_PERSISTENCE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [XP_W-1:0] xp;
		logic signed [XP_W-1:0] yp;
		logic signed [TOT_W-1:0] total;
		logic [NORM_W-1:0] norm;
		logic [AMP_W-1:0] amp;
	} oct_bus_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic [TOT_W-1:0] rem;
		logic [NORM_W-1:0] norm;
		logic [Q_W-1:0] q;
	} div_bus_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	// Dot product of one of the eight gradients with a corner offset.
	function automatic logic signed [DOT_W-1:0] grad_dot(
		input logic [2:0] g,
		input logic signed [CRN_W-1:0] x,
		input logic signed [CRN_W-1:0] y
	);
		logic signed [DOT_W-1:0] xe;
		logic signed [DOT_W-1:0] ye;
		logic signed [DOT_W-1:0] r;
		xe = DOT_W'(x);
		ye = DOT_W'(y);
		unique case (g)
			3'd0: r = xe + ye;
			3'd1: r = ye - xe;
			3'd2: r = xe - ye;
			3'd3: r = -xe - ye;
			3'd4: r = xe;
			3'd5: r = -xe;
			3'd6: r = ye;
			3'd7: r = -ye;
		endcase
		return r;
	endfunction
endpackage

// ----- hw/rtl/sn2f_ifs.sv -----
// Valid-ready channel interfaces for sample points and noise results.
interface sn2f_in_if;
	logic valid;
	logic ready;
	logic signed [sn2f_pkg::COORD_W-1:0] x_coord;
	logic signed [sn2f_pkg::COORD_W-1:0] y_coord;
	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface sn2f_out_if;
	logic valid;
	logic ready;
	logic signed [sn2f_pkg::NOISE_W-1:0] noise_value;
	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

// ----- hw/rtl/sn2f_octave.sv -----
// One octave cell: simplex noise at the scaled point, weighted into the running sum if active, else passed on.
module sn2f_octave (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [sn2f_pkg::CNT_W-1:0]      octave,
	input  logic [sn2f_pkg::CNT_W-1:0]      count,
	input  logic [sn2f_pkg::PERS_W-1:0]     persistence,
	input  logic                            in_valid,
	input  sn2f_pkg::oct_bus_t              in_bus,
	output logic                            out_valid,
	output sn2f_pkg::oct_bus_t              out_bus
);
	localparam int LAT = 15;
	localparam int PT_W = sn2f_pkg::PT_W;
	localparam int LAT_W = sn2f_pkg::LAT_W;
	localparam int FRAC_W = sn2f_pkg::FRAC_W;
	localparam int CRN_W = sn2f_pkg::CRN_W;
	localparam int SQ_W = sn2f_pkg::SQ_W;
	localparam int DOT_W = sn2f_pkg::DOT_W;
	localparam int TV_W = sn2f_pkg::TV_W;
	localparam int T2_W = sn2f_pkg::T2_W;
	localparam int T4_W = sn2f_pkg::T4_W;
	localparam int TERM_W = sn2f_pkg::TERM_W;
	localparam int SUM3_W = sn2f_pkg::SUM3_W;
	localparam int N_W = sn2f_pkg::N_W;
	localparam int AMP_W = sn2f_pkg::AMP_W;
	localparam int PERS_W = sn2f_pkg::PERS_W;
	localparam int PROD_W = sn2f_pkg::PROD_W;
	localparam int TOT_W = sn2f_pkg::TOT_W;
	localparam int NORM_W = sn2f_pkg::NORM_W;
	localparam int SH_W = sn2f_pkg::SH_W;
	localparam int SKP_W = PT_W + 15;
	localparam int UP_W = 31;
	localparam int GP_W = SUM3_W + 8;
	localparam logic signed [CRN_W-1:0] ONE_C = CRN_W'(65536);
	localparam logic signed [CRN_W-1:0] G2_C = CRN_W'(sn2f_pkg::G2Q);
	localparam logic signed [PT_W-1:0] HALF_C = PT_W'(64'sd2147483648);

	logic [LAT-1:0] vld_q;
	sn2f_pkg::oct_bus_t car_q [LAT-1];
	sn2f_pkg::oct_bus_t out_q;

	logic [SH_W-1:0] shamt;
	logic signed [PT_W-1:0] px;
	logic signed [PT_W-1:0] py;
	logic [SKP_W-1:0] skp;
	logic [LAT_W-1:0] xs;
	logic [LAT_W-1:0] ys;
	logic [FRAC_W:0] fsum;
	logic [UP_W-1:0] up;
	logic i1;
	logic signed [PT_W-1:0] tfull [3];
	logic signed [GP_W-1:0] gp;
	logic [AMP_W+PERS_W-1:0] ap;
	logic act;

	logic [PT_W-1:0] sum_s1;
	logic [LAT_W-1:0] pxl_s1, pyl_s1, pxl_s2, pyl_s2, skew_s2;
	logic [FRAC_W-1:0] fx_s3, fy_s3, fx_s4, fy_s4;
	logic [7:0] ii_s3, jj_s3, ii_s4, pa_s4, pb_s4;
	logic [14:0] u_s4;
	logic signed [CRN_W-1:0] x0_s5, y0_s5;
	logic [2:0] ga_s5, gb_s5, gc_s5, gd_s5;
	logic signed [CRN_W-1:0] cx_s6 [3];
	logic signed [CRN_W-1:0] cy_s6 [3];
	logic [2:0] g_s6 [3];
	logic signed [SQ_W-1:0] sqx_s7 [3];
	logic signed [SQ_W-1:0] sqy_s7 [3];
	logic signed [DOT_W-1:0] dot_s7 [3];
	logic signed [DOT_W-1:0] dot_s8 [3];
	logic signed [DOT_W-1:0] dot_s9 [3];
	logic signed [DOT_W-1:0] dot_s10 [3];
	logic [TV_W-1:0] tv_s8 [3];
	logic [T2_W-1:0] t2_s9 [3];
	logic [T4_W-1:0] t4_s10 [3];
	logic signed [TERM_W-1:0] term_s11 [3];
	logic signed [SUM3_W-1:0] sum3_s12;
	logic signed [N_W-1:0] n_s13;
	logic signed [PROD_W-1:0] prod_s14;
	logic [AMP_W-1:0] ampn_s14;

	assign shamt = SH_W'(16) - SH_W'(octave);
	assign px = PT_W'($signed(in_bus.xp) >>> shamt);
	assign py = PT_W'($signed(in_bus.yp) >>> shamt);
	assign skp = SKP_W'(sum_s1) * SKP_W'(sn2f_pkg::F2Q);
	assign xs = pxl_s2 + skew_s2;
	assign ys = pyl_s2 + skew_s2;
	assign fsum = {1'b0, fx_s3} + {1'b0, fy_s3};
	assign up = UP_W'(fsum) * UP_W'(sn2f_pkg::G2Q);
	assign i1 = x0_s5 > y0_s5;
	assign gp = sum3_s12 * $signed(8'(sn2f_pkg::NOISE_GAIN));
	assign ap = car_q[12].amp * persistence;
	assign act = octave < count;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tfull[k] = HALF_C - PT_W'(sqx_s7[k]) - PT_W'(sqy_s7[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			car_q[0] <= in_bus;
			for (int k = 1; k < LAT - 1; k++) begin
				car_q[k] <= car_q[k-1];
			end
			sum_s1 <= px + py;
			pxl_s1 <= px[LAT_W-1:0];
			pyl_s1 <= py[LAT_W-1:0];
			skew_s2 <= skp[FRAC_W +: LAT_W];
			pxl_s2 <= pxl_s1;
			pyl_s2 <= pyl_s1;
			fx_s3 <= xs[FRAC_W-1:0];
			fy_s3 <= ys[FRAC_W-1:0];
			ii_s3 <= xs[LAT_W-1:FRAC_W];
			jj_s3 <= ys[LAT_W-1:FRAC_W];
			u_s4 <= up[FRAC_W +: 15];
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			ii_s4 <= ii_s3;
			pa_s4 <= sn2f_pkg::PERM[jj_s3];
			pb_s4 <= sn2f_pkg::PERM[jj_s3 + 8'd1];
			x0_s5 <= $signed(CRN_W'(fx_s4)) - $signed(CRN_W'(u_s4));
			y0_s5 <= $signed(CRN_W'(fy_s4)) - $signed(CRN_W'(u_s4));
			ga_s5 <= sn2f_pkg::PERM[ii_s4 + pa_s4][2:0];
			gb_s5 <= sn2f_pkg::PERM[ii_s4 + 8'd1 + pb_s4][2:0];
			gc_s5 <= sn2f_pkg::PERM[ii_s4 + 8'd1 + pa_s4][2:0];
			gd_s5 <= sn2f_pkg::PERM[ii_s4 + pb_s4][2:0];
			cx_s6[0] <= x0_s5;
			cy_s6[0] <= y0_s5;
			cx_s6[1] <= x0_s5 - (i1 ? ONE_C : '0) + G2_C;
			cy_s6[1] <= y0_s5 - (i1 ? '0 : ONE_C) + G2_C;
			cx_s6[2] <= x0_s5 - ONE_C + G2_C + G2_C;
			cy_s6[2] <= y0_s5 - ONE_C + G2_C + G2_C;
			g_s6[0] <= ga_s5;
			g_s6[1] <= i1 ? gc_s5 : gd_s5;
			g_s6[2] <= gb_s5;
			for (int k = 0; k < 3; k++) begin
				sqx_s7[k] <= cx_s6[k] * cx_s6[k];
				sqy_s7[k] <= cy_s6[k] * cy_s6[k];
				dot_s7[k] <= sn2f_pkg::grad_dot(g_s6[k], cx_s6[k], cy_s6[k]);
				tv_s8[k] <= (tfull[k] > 0) ? tfull[k][TV_W-1:0] : '0;
				dot_s8[k] <= dot_s7[k];
				t2_s9[k] <= T2_W'((64'(tv_s8[k]) * 64'(tv_s8[k])) >> 32);
				dot_s9[k] <= dot_s8[k];
				t4_s10[k] <= T4_W'((62'(t2_s9[k]) * 62'(t2_s9[k])) >> 32);
				dot_s10[k] <= dot_s9[k];
				term_s11[k] <= $signed({1'b0, t4_s10[k]}) * dot_s10[k];
			end
			sum3_s12 <= SUM3_W'(term_s11[0]) + SUM3_W'(term_s11[1]) + SUM3_W'(term_s11[2]);
			n_s13 <= gp[18 +: N_W];
			prod_s14 <= n_s13 * $signed({1'b0, car_q[12].amp});
			ampn_s14 <= ap[15 +: AMP_W];
			out_q.xp <= car_q[13].xp;
			out_q.yp <= car_q[13].yp;
			if (act) begin
				out_q.total <= car_q[13].total + TOT_W'($signed(prod_s14[PROD_W-1:15]));
				out_q.norm <= car_q[13].norm + NORM_W'(car_q[13].amp);
				out_q.amp <= ampn_s14;
			end else begin
				out_q.total <= car_q[13].total;
				out_q.norm <= car_q[13].norm;
				out_q.amp <= car_q[13].amp;
			end
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign out_bus = out_q;
endmodule

// ----- hw/rtl/sn2f_div_step.sv -----
// One restoring division cell: yields one quotient bit of sum over norm.
module sn2f_div_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [sn2f_pkg::SH_W-1:0]   shift,
	input  logic                        in_valid,
	input  sn2f_pkg::div_bus_t          in_bus,
	output logic                        out_valid,
	output sn2f_pkg::div_bus_t          out_bus
);
	localparam int TOT_W = sn2f_pkg::TOT_W;
	localparam int Q_W = sn2f_pkg::Q_W;

	logic [TOT_W-1:0] dn;
	logic fits;
	logic vld_q;
	sn2f_pkg::div_bus_t bus_q;

	assign dn = TOT_W'(in_bus.norm) << shift;
	assign fits = in_bus.rem >= dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bus_q.neg <= in_bus.neg;
			bus_q.ovf <= in_bus.ovf;
			bus_q.norm <= in_bus.norm;
			bus_q.rem <= fits ? in_bus.rem - dn : in_bus.rem;
			bus_q.q <= {in_bus.q[Q_W-2:0], fits};
		end
	end

	assign out_valid = vld_q;
	assign out_bus = bus_q;
endmodule

// ----- hw/rtl/simplex_noise_2d_fbm_core.sv -----
// Top level of the fractal simplex noise core: config, octave chain, divider, output.
//
//   port      dir   handshake     contents
//   sample    in    valid/ready   x_coord, y_coord (signed Q16.16)
//   result    out   valid/ready   noise_value (signed Q1.15)
//   cfg       in    cfg_we        cfg_index, cfg_data
//
// One item is taken per cycle. The pipeline runs through the input register,
// the chain of octave cells (15 stages each), a preparation register, the
// seventeen cells of the bit-serial divider pipeline and the output register.
// All stages move together and halt while the output register holds an item
// that is not taken. Reset clears valid flags and loads the register defaults.
`include "simplex_noise_2d_fbm_core_assert.svh"
module simplex_noise_2d_fbm_core (
	input  logic                             clk,
	input  logic                             arst_n,
	sn2f_in_if.sink                          sample,
	sn2f_out_if.source                       result,
	input  logic                             cfg_we,
	input  logic [sn2f_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sn2f_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int MAX_OCTAVES = sn2f_pkg::MAX_OCTAVES;
	localparam int CNT_W = sn2f_pkg::CNT_W;
	localparam int XP_W = sn2f_pkg::XP_W;
	localparam int TOT_W = sn2f_pkg::TOT_W;
	localparam int NORM_W = sn2f_pkg::NORM_W;
	localparam int AMP_W = sn2f_pkg::AMP_W;
	localparam int Q_W = sn2f_pkg::Q_W;
	localparam int SH_W = sn2f_pkg::SH_W;
	localparam int NOISE_W = sn2f_pkg::NOISE_W;

	logic [sn2f_pkg::SCALE_W-1:0] scale_q;
	logic [sn2f_pkg::COUNT_W-1:0] count_q;
	logic [sn2f_pkg::PERS_W-1:0] pers_q;
	logic [CNT_W-1:0] oct_eff;
	logic adv;

	logic signed [XP_W:0] xprod;
	logic signed [XP_W:0] yprod;
	logic oct_v [MAX_OCTAVES+1];
	sn2f_pkg::oct_bus_t oct_b [MAX_OCTAVES+1];
	logic head_v_s1;
	sn2f_pkg::oct_bus_t head_s1;

	logic tneg;
	logic [TOT_W-1:0] tmag;
	logic div_v [Q_W+1];
	sn2f_pkg::div_bus_t div_b [Q_W+1];
	logic prep_v_s1;
	sn2f_pkg::div_bus_t prep_s1;

	logic out_valid_q;
	logic signed [NOISE_W-1:0] noise_q;
	logic signed [NOISE_W-1:0] sat;
	sn2f_pkg::div_bus_t last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= sn2f_pkg::SCALE_W'(65536);
			count_q <= sn2f_pkg::COUNT_W'(1);
			pers_q <= sn2f_pkg::PERS_W'(16384);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sn2f_pkg::REG_SCALE: scale_q <= cfg_data[sn2f_pkg::SCALE_W-1:0];
				sn2f_pkg::REG_OCTAVES: count_q <= cfg_data[sn2f_pkg::COUNT_W-1:0];
				sn2f_pkg::REG_PERSISTENCE: pers_q <= cfg_data[sn2f_pkg::PERS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (count_q == '0) begin
			oct_eff = CNT_W'(1);
		end else if (6'(count_q) > 6'(MAX_OCTAVES)) begin
			oct_eff = CNT_W'(MAX_OCTAVES);
		end else begin
			oct_eff = CNT_W'(count_q);
		end
	end

	assign adv = !out_valid_q || result.ready;
	assign sample.ready = adv;

	assign xprod = sample.x_coord * $signed({1'b0, scale_q});
	assign yprod = sample.y_coord * $signed({1'b0, scale_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_s1 <= 1'b0;
		end else if (adv) begin
			head_v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_s1.xp <= xprod[XP_W-1:0];
			head_s1.yp <= yprod[XP_W-1:0];
			head_s1.total <= '0;
			head_s1.norm <= '0;
			head_s1.amp <= AMP_W'(sn2f_pkg::AMP_ONE);
		end
	end

	assign oct_v[0] = head_v_s1;
	assign oct_b[0] = head_s1;

	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
		sn2f_octave u_octave (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.octave      (CNT_W'(o)),
			.count       (oct_eff),
			.persistence (pers_q),
			.in_valid    (oct_v[o]),
			.in_bus      (oct_b[o]),
			.out_valid   (oct_v[o+1]),
			.out_bus     (oct_b[o+1])
		);
	end

	assign tneg = oct_b[MAX_OCTAVES].total < 0;
	assign tmag = tneg ? TOT_W'(-oct_b[MAX_OCTAVES].total) : TOT_W'(oct_b[MAX_OCTAVES].total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_v_s1 <= 1'b0;
		end else if (adv) begin
			prep_v_s1 <= oct_v[MAX_OCTAVES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s1.neg <= tneg;
			prep_s1.ovf <= (TOT_W+1)'(tmag) >=
				((TOT_W+1)'(oct_b[MAX_OCTAVES].norm) << Q_W);
			prep_s1.rem <= tmag;
			prep_s1.norm <= oct_b[MAX_OCTAVES].norm;
			prep_s1.q <= '0;
		end
	end

	assign div_v[0] = prep_v_s1;
	assign div_b[0] = prep_s1;

	for (genvar d = 0; d < Q_W; d++) begin : g_div
		sn2f_div_step u_div_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.shift     (SH_W'(Q_W - 1 - d)),
			.in_valid  (div_v[d]),
			.in_bus    (div_b[d]),
			.out_valid (div_v[d+1]),
			.out_bus   (div_b[d+1])
		);
	end

	assign last = div_b[Q_W];

	always_comb begin
		if (last.neg) begin
			if (last.ovf || last.q > Q_W'(32768)) begin
				sat = NOISE_W'(-32768);
			end else begin
				sat = NOISE_W'(-$signed({1'b0, last.q}));
			end
		end else begin
			if (last.ovf || last.q > Q_W'(32767)) begin
				sat = NOISE_W'(32767);
			end else begin
				sat = NOISE_W'(last.q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= sat;
		end
	end

	assign result.valid = out_valid_q;
	assign result.noise_value = noise_q;

	`SN2F_ASSERT(a_stall_blocks_input, (out_valid_q && !result.ready) |-> !sample.ready, "input taken while output stalled")
	`SN2F_ASSERT(a_norm_positive, oct_v[MAX_OCTAVES] |-> (oct_b[MAX_OCTAVES].norm >= NORM_W'(32768)), "amplitude sum below one")
	`SN2F_ASSERT(a_rem_below_norm, (div_v[Q_W] && !last.ovf) |-> (last.rem < TOT_W'(last.norm)), "division remainder not reduced")
	`SN2F_ASSERT_NEXT(a_out_from_div, adv && div_v[Q_W], out_valid_q, "divider item not registered at output")
endmodule
